### hw/rtl/mcr_pkg.sv
package mcr_pkg;

  // Fixed field widths
  localparam int CX_W     = 12;
  localparam int RAD_IN_W = 6;
  localparam int COLOR_W  = 32;
  localparam int OFS_W    = 28;
  localparam int LPP_W    = 13;   // pixels_per_line register
  // Internal widths sized for the widest legal parameter values
  localparam int COORD_W  = 7;    // radius up to 63, y up to radius + 1
  localparam int LINE_W   = 14;   // clamped line length up to 8191
  localparam int CYP_W    = CX_W + LINE_W;     // center_y * line length
  localparam int RP_W     = COORD_W + LINE_W;  // radius * line length
  localparam int ERR_W    = 11;   // midpoint error term, signed
  localparam int STEP_W   = 6;
  localparam int MAX_STEPS = 46;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_PIXEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 2'd1;

  typedef struct packed {
    logic [CX_W-1:0]     center_x;
    logic [CX_W-1:0]     center_y;
    logic [RAD_IN_W-1:0] radius;
    logic [COLOR_W-1:0]  color;
  } req_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] offset_0;
    logic signed [OFS_W-1:0] offset_1;
    logic signed [OFS_W-1:0] offset_2;
    logic signed [OFS_W-1:0] offset_3;
    logic signed [OFS_W-1:0] offset_4;
    logic signed [OFS_W-1:0] offset_5;
    logic signed [OFS_W-1:0] offset_6;
    logic signed [OFS_W-1:0] offset_7;
    logic [COLOR_W-1:0]      pixel_word;
    logic                    last_step;
  } res_t;

  // Prepared circle job handed from front to back
  typedef struct packed {
    logic [OFS_W-1:0]   base;       // cx + cy * line, in pixels
    logic [RP_W-1:0]    rad_line;   // radius * line
    logic [COORD_W-1:0] rad;
    logic [LINE_W-1:0]  line;
    logic [COLOR_W-1:0] word;
    logic               wide;
  } job_t;

endpackage

### hw/rtl/mcr_front.sv
module mcr_front #(
  parameter int MAX_RADIUS      = 63,
  parameter int MAX_LINE_PIXELS = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  mcr_pkg::req_t             req,
  input  logic                      wide_pixel_mode,
  input  logic [mcr_pkg::LPP_W-1:0] pixels_per_line,
  output logic                      job_valid,
  input  logic                      job_ready,
  output mcr_pkg::job_t             job
);

  typedef struct packed {
    logic [mcr_pkg::CX_W-1:0]    cx;
    logic [mcr_pkg::CYP_W-1:0]   cy_line;
    logic [mcr_pkg::RP_W-1:0]    rad_line;
    logic [mcr_pkg::COORD_W-1:0] rad;
    logic [mcr_pkg::LINE_W-1:0]  line;
    logic [mcr_pkg::COLOR_W-1:0] word;
    logic                        wide;
  } prod_t;

  function automatic logic [mcr_pkg::COLOR_W-1:0] pack565(
      input logic [mcr_pkg::COLOR_W-1:0] c);
    pack565 = {16'd0, c[23:19], c[15:10], c[7:3]};
  endfunction

  logic                          s1_valid;
  prod_t                         s1;
  logic                          s2_valid;
  mcr_pkg::job_t                 s2;
  logic                          s2_open;
  logic                          accept;
  logic [mcr_pkg::COORD_W-1:0]   rad_eff;
  logic [mcr_pkg::LINE_W-1:0]    line_eff;
  logic [mcr_pkg::CYP_W-1:0]     cy_line_w;
  logic [mcr_pkg::RP_W-1:0]      rad_line_w;

  // Handshake: stage 2 frees when its job moves into the queue
  assign s2_open   = !s2_valid || job_ready;
  assign req_stall = s1_valid && !s2_open;
  assign accept    = req_valid && !req_stall;

  // Classify: clamp radius and line length, then the two products
  always_comb begin
    rad_eff = {1'b0, req.radius};
    if ({1'b0, req.radius} > mcr_pkg::COORD_W'(MAX_RADIUS)) begin
      rad_eff = mcr_pkg::COORD_W'(MAX_RADIUS);
    end
    line_eff = {1'b0, pixels_per_line};
    if ({1'b0, pixels_per_line} > mcr_pkg::LINE_W'(MAX_LINE_PIXELS)) begin
      line_eff = mcr_pkg::LINE_W'(MAX_LINE_PIXELS);
    end
    cy_line_w  = {{mcr_pkg::LINE_W{1'b0}}, req.center_y} *
                 {{mcr_pkg::CX_W{1'b0}}, line_eff};
    rad_line_w = {{mcr_pkg::LINE_W{1'b0}}, rad_eff} *
                 {{mcr_pkg::COORD_W{1'b0}}, line_eff};
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s2_open) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1.cx       <= req.center_x;
      s1.cy_line  <= cy_line_w;
      s1.rad_line <= rad_line_w;
      s1.rad      <= rad_eff;
      s1.line     <= line_eff;
      s1.word     <= wide_pixel_mode ? req.color : pack565(req.color);
      s1.wide     <= wide_pixel_mode;
    end
  end

  // Stage 2: center pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
    if (s2_open && s1_valid) begin
      s2.base     <= {{(mcr_pkg::OFS_W-mcr_pkg::CX_W){1'b0}}, s1.cx} +
                     {{(mcr_pkg::OFS_W-mcr_pkg::CYP_W){1'b0}}, s1.cy_line};
      s2.rad_line <= s1.rad_line;
      s2.rad      <= s1.rad;
      s2.line     <= s1.line;
      s2.word     <= s1.word;
      s2.wide     <= s1.wide;
    end
  end

  assign job_valid = s2_valid;
  assign job       = s2;

endmodule

### hw/rtl/mcr_queue.sv
module mcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mcr_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop,
  output mcr_pkg::job_t pop_job
);

  localparam int PTR_W = $clog2(mcr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

  mcr_pkg::job_t     slots [mcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = slots[rd_ptr];

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/mcr_back.sv
module mcr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_pop,
  input  mcr_pkg::job_t job,
  output logic          pix_valid,
  input  logic          pix_stall,
  output mcr_pkg::res_t pix
);

  localparam int OW = mcr_pkg::OFS_W;
  localparam int CW = mcr_pkg::COORD_W;
  localparam int EW = mcr_pkg::ERR_W;

  function automatic logic [OW-1:0] scale(input logic [OW-1:0] s, input logic wide);
    scale = wide ? {s[OW-3:0], 2'b00} : {s[OW-2:0], 1'b0};
  endfunction

  logic                          busy;
  logic [CW-1:0]                 x;
  logic [CW-1:0]                 y;
  logic signed [EW-1:0]          err;
  logic [mcr_pkg::STEP_W-1:0]    step_cnt;
  logic [OW-1:0]                 row_yp;   // base + y * line
  logic [OW-1:0]                 row_ym;   // base - y * line
  logic [OW-1:0]                 row_xp;   // base + x * line
  logic [OW-1:0]                 row_xm;   // base - x * line
  logic [OW-1:0]                 line;
  logic [mcr_pkg::COLOR_W-1:0]   word;
  logic                          wide;

  logic                          step;
  logic [CW-1:0]                 x_next;
  logic [CW-1:0]                 y_next;
  logic signed [EW-1:0]          err_next;
  logic                          last;
  logic [OW-1:0]                 dx;
  logic [OW-1:0]                 dy;
  logic [OW-1:0]                 rad_line;

  assign job_pop  = !busy && job_valid;
  assign step     = busy && (!pix_valid || !pix_stall);
  assign dx       = {{(OW-CW){1'b0}}, x};
  assign dy       = {{(OW-CW){1'b0}}, y};
  assign rad_line = {{(OW-mcr_pkg::RP_W){1'b0}}, job.rad_line};

  // Midpoint update
  always_comb begin
    y_next = y + 1'b1;
    if (err <= 0) begin
      x_next   = x;
      err_next = EW'(err + 2 * $signed({{(EW-CW){1'b0}}, y_next}) + EW'(1));
    end else begin
      x_next   = x - 1'b1;
      err_next = EW'(err + 2 * ($signed({{(EW-CW){1'b0}}, y_next}) -
                                $signed({{(EW-CW){1'b0}}, x_next})) + EW'(1));
    end
    last = (x_next < y_next) ||
           (step_cnt == mcr_pkg::STEP_W'(mcr_pkg::MAX_STEPS - 1));
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_pop) begin
      busy <= 1'b1;
    end else if (step && last) begin
      busy <= 1'b0;
    end
    if (job_pop) begin
      x        <= job.rad;
      y        <= '0;
      err      <= '0;
      step_cnt <= '0;
      row_yp   <= job.base;
      row_ym   <= job.base;
      row_xp   <= job.base + rad_line;
      row_xm   <= job.base - rad_line;
      line     <= {{(OW-mcr_pkg::LINE_W){1'b0}}, job.line};
      word     <= job.word;
      wide     <= job.wide;
    end else if (step) begin
      x        <= x_next;
      y        <= y_next;
      err      <= err_next;
      step_cnt <= step_cnt + 1'b1;
      row_yp   <= row_yp + line;
      row_ym   <= row_ym - line;
      if (x_next != x) begin
        row_xp <= row_xp - line;
        row_xm <= row_xm + line;
      end
    end
  end

  // Output register with the eight octant offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (step) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
    if (step) begin
      pix.offset_0   <= scale(row_yp + dx, wide);
      pix.offset_1   <= scale(row_xp + dy, wide);
      pix.offset_2   <= scale(row_xp - dy, wide);
      pix.offset_3   <= scale(row_yp - dx, wide);
      pix.offset_4   <= scale(row_ym - dx, wide);
      pix.offset_5   <= scale(row_xm - dy, wide);
      pix.offset_6   <= scale(row_xm + dy, wide);
      pix.offset_7   <= scale(row_ym + dx, wide);
      pix.pixel_word <= word;
      pix.last_step  <= last;
    end
  end

  // Loop invariant: a running circle never has y past x
  a_y_within_x: assert property (@(posedge clk) disable iff (rst)
    busy |-> (y <= x))
    else $error("step with y above x");

  a_step_budget: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step_cnt < mcr_pkg::STEP_W'(mcr_pkg::MAX_STEPS)))
    else $error("step count past budget");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (busy && y == '0 && step_cnt == '0))
    else $error("job pop did not start a run");

endmodule

### hw/rtl/midpoint_circle_rasterizer_core.sv
// A first result passes the two front stages, the job queue, the step registers and
// the output register. Throughput: a circle of radius r gives about r/sqrt(2) + 1
// results (at most 46), one per cycle unless pix_stall holds the output; the next job
// leaves the queue once the step unit is idle. The two-stage front and a 2-entry job
// queue take new requests while a circle runs. Reset (rst, synchronous, active high)
// clears all valid state and sets 32 bpp mode with 800 pixels per line.
module midpoint_circle_rasterizer_core #(
  parameter int MAX_RADIUS      = 63,
  parameter int MAX_LINE_PIXELS = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  mcr_pkg::req_t                  req,
  output logic                           pix_valid,
  input  logic                           pix_stall,
  output mcr_pkg::res_t                  pix,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                      wide_pixel_mode;
  logic [mcr_pkg::LPP_W-1:0] pixels_per_line;
  logic                      fq_valid;
  logic                      fq_ready;
  mcr_pkg::job_t             fq_job;
  logic                      qb_valid;
  logic                      qb_pop;
  mcr_pkg::job_t             qb_job;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_pixel_mode <= 1'b1;
      pixels_per_line <= mcr_pkg::LPP_W'(800);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcr_pkg::REG_WIDE_PIXEL_MODE: wide_pixel_mode <= cfg_data[0];
        mcr_pkg::REG_PIXELS_PER_LINE: pixels_per_line <= cfg_data[mcr_pkg::LPP_W-1:0];
        default: ;
      endcase
    end
  end

  mcr_front #(
    .MAX_RADIUS      (MAX_RADIUS),
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .wide_pixel_mode (wide_pixel_mode),
    .pixels_per_line (pixels_per_line),
    .job_valid       (fq_valid),
    .job_ready       (fq_ready),
    .job             (fq_job)
  );

  mcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_job    (qb_job)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_pop   (qb_pop),
    .job       (qb_job),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CIRCLE_MAX_RADIUS = 63;
  localparam int LINE_MAX_PIXELS   = 4096;
  // Index with no register behind it; a write there must change nothing
  localparam logic [mcr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  mcr_pkg::req_t req = '0;
  logic pix_valid;
  logic pix_stall = 1'b0;
  mcr_pkg::res_t pix;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers
  logic wide_mode = 1'b1;
  logic [mcr_pkg::LPP_W-1:0] line_pixels = 13'd800;

  mcr_pkg::req_t pending_circles[$];
  mcr_pkg::res_t expected_steps[$];
  mcr_pkg::res_t step_want;
  int mismatches = 0;
  int send_idle_pct = 21;
  int recv_stall_pct = 88;

  midpoint_circle_rasterizer_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Byte offset of one octant point, wrapped to the offset width
  function automatic logic [mcr_pkg::OFS_W-1:0] byte_ofs(longint cx, longint cy, longint dx,
                                                         longint dy, longint line,
                                                         longint bpp);
    longint pix_idx;
    pix_idx = (cx + dx) + (cy + dy) * line;
    return mcr_pkg::OFS_W'(pix_idx * bpp);
  endfunction

  // Walk the midpoint loop for one circle and queue every step it yields
  function automatic void trace_circle(mcr_pkg::req_t c);
    longint cx, cy, line, bpp;
    int x, y, err, steps;
    logic [mcr_pkg::COLOR_W-1:0] word;
    mcr_pkg::res_t step;
    cx = longint'(c.center_x);
    cy = longint'(c.center_y);
    x = int'(c.radius);
    if (x > CIRCLE_MAX_RADIUS) x = CIRCLE_MAX_RADIUS;
    line = longint'(line_pixels);
    if (line > LINE_MAX_PIXELS) line = LINE_MAX_PIXELS;
    bpp = wide_mode ? 4 : 2;
    word = wide_mode ? c.color
                     : {16'd0, c.color[23:19], c.color[15:10], c.color[7:3]};
    y = 0;
    err = 0;
    steps = 0;
    while (x >= y && steps < mcr_pkg::MAX_STEPS) begin
      step.offset_0 = byte_ofs(cx, cy, x, y, line, bpp);
      step.offset_1 = byte_ofs(cx, cy, y, x, line, bpp);
      step.offset_2 = byte_ofs(cx, cy, -y, x, line, bpp);
      step.offset_3 = byte_ofs(cx, cy, -x, y, line, bpp);
      step.offset_4 = byte_ofs(cx, cy, -x, -y, line, bpp);
      step.offset_5 = byte_ofs(cx, cy, -y, -x, line, bpp);
      step.offset_6 = byte_ofs(cx, cy, y, -x, line, bpp);
      step.offset_7 = byte_ofs(cx, cy, x, -y, line, bpp);
      step.pixel_word = word;
      steps++;
      y++;
      if (err <= 0) begin
        err += 2 * y + 1;
      end else begin
        x--;
        err += 2 * (y - x) + 1;
      end
      step.last_step = !(x >= y && steps < mcr_pkg::MAX_STEPS);
      expected_steps.push_back(step);
    end
  endfunction

  task automatic cmp_field(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fld, want, got);
      mismatches++;
    end
  endtask

  // Request driver: hold each request until taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) trace_circle(req);
      if (!req_valid || !req_stall) begin
        if (pending_circles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_circles.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    pix_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, pix);
        mismatches++;
      end else begin
        step_want = expected_steps.pop_front();
        cmp_field("offset_0", 32'(step_want.offset_0), 32'(pix.offset_0));
        cmp_field("offset_1", 32'(step_want.offset_1), 32'(pix.offset_1));
        cmp_field("offset_2", 32'(step_want.offset_2), 32'(pix.offset_2));
        cmp_field("offset_3", 32'(step_want.offset_3), 32'(pix.offset_3));
        cmp_field("offset_4", 32'(step_want.offset_4), 32'(pix.offset_4));
        cmp_field("offset_5", 32'(step_want.offset_5), 32'(pix.offset_5));
        cmp_field("offset_6", 32'(step_want.offset_6), 32'(pix.offset_6));
        cmp_field("offset_7", 32'(step_want.offset_7), 32'(pix.offset_7));
        cmp_field("pixel_word", step_want.pixel_word, pix.pixel_word);
        cmp_field("last_step", 32'(step_want.last_step), 32'(pix.last_step));
      end
    end
  end

  task automatic push_circle(int cx, int cy, int r, logic [31:0] color);
    mcr_pkg::req_t c;
    c.center_x = mcr_pkg::CX_W'(cx);
    c.center_y = mcr_pkg::CX_W'(cy);
    c.radius = mcr_pkg::RAD_IN_W'(r);
    c.color = color;
    pending_circles.push_back(c);
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      push_circle($urandom_range(4095), $urandom_range(4095), $urandom_range(63), $urandom());
    end
  endtask

  // Block until every request is taken and every step has come out;
  // checked at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_circles.size() > 0 || req_valid || expected_steps.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [mcr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mcr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mcr_pkg::REG_WIDE_PIXEL_MODE) wide_mode = data[0];
    else if (idx == mcr_pkg::REG_PIXELS_PER_LINE) line_pixels = data;
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 32 bpp, 800 pixels per line
    push_circle(100, 50, 0, 32'h12345678);
    push_circle(0, 0, 63, 32'hFFFFFFFF);
    push_circle(4095, 4095, 63, 32'h00000000);
    push_circle(2048, 1024, 1, 32'hA5A5A5A5);
    push_circle(1, 1, 2, 32'h5A5A5A5A);
    push_circle(640, 480, 10, 32'h00FF00FF);
    wait_drained();

    // 16 bpp with zero line length, mode bit written with junk above it
    write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'h1FFE);
    write_reg(mcr_pkg::REG_PIXELS_PER_LINE, 13'd0);
    push_circle(300, 200, 5, 32'hFF00FF00);
    push_circle(0, 4095, 0, 32'hFFFFFFFF);
    push_circle(4095, 4095, 63, 32'h00FFFFFF);
    wait_drained();

    // Line length above the clamp
    write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'h0001);
    write_reg(mcr_pkg::REG_PIXELS_PER_LINE, 13'h1FFF);
    push_circle(4095, 4095, 63, 32'hDEADBEEF);
    push_circle(0, 4095, 7, 32'h01234567);
    wait_drained();

    // Single-pixel lines in 16 bpp, plus a write to an unmapped index
    write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'h0000);
    write_reg(mcr_pkg::REG_PIXELS_PER_LINE, 13'd1);
    write_reg(REG_UNMAPPED, 13'h1555);
    push_circle(4095, 0, 33, 32'h00FFFFFF);
    push_circle(17, 9, 44, 32'h80808080);
    wait_drained();

    // Random groups, each with its own settings
    for (int grp = 0; grp < 5; grp++) begin
      if (grp == 2) begin
        send_idle_pct = 88;
        recv_stall_pct = 21;
      end else if (grp == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (grp)
        0: begin
          write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'd0);
          write_reg(mcr_pkg::REG_PIXELS_PER_LINE, 13'd4096);
        end
        1: begin
          write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'd1);
          write_reg(mcr_pkg::REG_PIXELS_PER_LINE,
                    mcr_pkg::CFG_DATA_W'($urandom_range(4096)));
        end
        2: begin
          write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'd0);
          write_reg(mcr_pkg::REG_PIXELS_PER_LINE,
                    mcr_pkg::CFG_DATA_W'($urandom_range(8191)));
        end
        3: begin
          write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE, 13'd1);
          write_reg(mcr_pkg::REG_PIXELS_PER_LINE,
                    mcr_pkg::CFG_DATA_W'($urandom_range(8191, 4095)));
        end
        default: begin
          write_reg(mcr_pkg::REG_WIDE_PIXEL_MODE,
                    mcr_pkg::CFG_DATA_W'($urandom_range(8191)));
          write_reg(mcr_pkg::REG_PIXELS_PER_LINE,
                    mcr_pkg::CFG_DATA_W'($urandom_range(8191)));
        end
      endcase
      add_random(28);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
